>>> hw/rtl/lprl_pkg.sv
// Package for the longest prefix route lookup block.
// Holds the action codes, the sequencer states and the route entry and result types.
// No dependencies.
package lprl_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 2;
  localparam int SLOT_W = 4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] destination;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] hop_gateway;
    logic [PORT_W-1:0] out_port;
  } route_result_t;

  typedef struct packed {
    logic         en;
    logic         valid;
    route_entry_t entry;
  } table_write_t;

endpackage

>>> hw/rtl/lprl_table.sv
// Route table storage: one memory of route entries and a valid bit per slot.
// Valid bits clear at reset; entries are undefined until written.
// Depends on lprl_pkg.
module lprl_table
  import lprl_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  table_write_t wr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] rd_addr,
  output route_entry_t rd_entry,
  output logic         rd_valid
);

  route_entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_addr] <= wr.valid;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

>>> hw/rtl/lprl_scan.sv
// Lookup sequencer: walks the table one slot per cycle through a shared compare unit
// and keeps the best match so far. Depends on lprl_pkg.
module lprl_scan
  import lprl_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] lookup_address,
  input  logic              out_free,
  input  route_entry_t      rd_entry,
  input  logic              rd_valid,
  output logic [IDX_W-1:0]  rd_addr,
  output logic              idle,
  output logic              res_valid,
  output route_result_t     result
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  scan_state_t state, state_next;
  logic [IDX_W-1:0] ridx;
  logic eval;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] best;
  logic hit;
  logic [ADDR_W-1:0] gw;
  logic [PORT_W-1:0] port;
  logic take;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (ridx == LAST) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle      = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    rd_addr   = ridx;
    result.found       = hit;
    result.hop_gateway = gw;
    result.out_port    = port;
  end

  assign take = eval && rd_valid
             && (((addr ^ rd_entry.destination) & rd_entry.mask) == '0)
             && ((rd_entry.mask & best) == best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ridx  <= '0;
      eval  <= 1'b0;
    end else begin
      state <= state_next;
      eval  <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        ridx <= ridx + 1'b1;
      end else begin
        ridx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      addr <= lookup_address;
      best <= '0;
      hit  <= 1'b0;
      gw   <= '0;
      port <= '0;
    end else if (take) begin
      best <= rd_entry.mask;
      hit  <= 1'b1;
      gw   <= rd_entry.gateway;
      port <= rd_entry.port;
    end
  end

endmodule

>>> hw/rtl/longest_prefix_route_lookup.sv
// Top level of the longest prefix route lookup block.
// Instantiates lprl_table and lprl_scan; depends on lprl_pkg.
//
// The input stream carries one word per item; s_tuser selects a table write or a
// lookup. A write gives no result and leaves the input ready. Writes with a slot
// index at or beyond ENTRIES or a port at or beyond PORTS are dropped. A lookup
// scans every slot, one slot per cycle through a single compare unit, and passes
// through the scan, drain and done states before its result word is loaded into
// the output register; the input is not ready while it is in those states.
// The input is ready again in the same cycle that the result word is in the output
// register, so a new lookup is not taken before the last one is through.
// The result of a lookup is one word on the output stream. When the receiver
// stalls, the result waits in the output register; a following write is still
// taken, but a new lookup holds in its done state until the register frees.
// Reset clears all valid marks, so the table starts empty and every lookup
// reports no match until routes are written. No clearing pass is needed.
module longest_prefix_route_lookup
  import lprl_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int PORTS   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot_index[3:0], slot_valid[4], slot_destination[36:5], slot_mask[68:37],
  // slot_gateway[100:69], slot_port[102:101], lookup_address[134:103], zero[135]
  input  logic [135:0] s_tdata,
  // action[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], hop_gateway[32:1], out_port[34:33], zero[39:35]
  output logic [39:0]  m_tdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic accept;
  logic scan_idle;
  logic res_valid;
  logic out_free;
  logic [SLOT_W-1:0] slot_index;
  logic [PORT_W-1:0] slot_port;
  logic slot_ok;
  table_write_t wr;
  logic [IDX_W-1:0] rd_addr;
  route_entry_t rd_entry;
  logic rd_valid;
  route_result_t result;

  assign s_tready   = scan_idle;
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign slot_index = s_tdata[3:0];
  assign slot_port  = s_tdata[102:101];
  assign slot_ok    = (int'(slot_index) < ENTRIES) && (int'(slot_port) < PORTS);

  always_comb begin
    wr.en                = accept && (s_tuser[0] == ACT_WRITE) && slot_ok;
    wr.valid             = s_tdata[4];
    wr.entry.destination = s_tdata[36:5];
    wr.entry.mask        = s_tdata[68:37];
    wr.entry.gateway     = s_tdata[100:69];
    wr.entry.port        = slot_port;
  end

  lprl_table #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_addr (IDX_W'(slot_index)),
    .rd_addr (rd_addr),
    .rd_entry(rd_entry),
    .rd_valid(rd_valid)
  );

  lprl_scan #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .start         (accept && (s_tuser[0] == ACT_LOOKUP)),
    .lookup_address(s_tdata[134:103]),
    .out_free      (out_free),
    .rd_entry      (rd_entry),
    .rd_valid      (rd_valid),
    .rd_addr       (rd_addr),
    .idle          (scan_idle),
    .res_valid     (res_valid),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_tdata <= {5'b0, result.out_port, result.hop_gateway, result.found};
    end
  end

endmodule

>>> bench/tb_longest_prefix_route_lookup.sv
// Self-checking bench for longest_prefix_route_lookup: table writes and lookups over the
// input stream, each lookup result predicted and compared on the output stream.
// Depends on lprl_pkg and the longest_prefix_route_lookup RTL.
module tb_longest_prefix_route_lookup
  import lprl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = 16;
  localparam int PORTS          = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 375;

  typedef struct {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic              live;
    route_entry_t      route;
    logic [ADDR_W-1:0] address;
  } route_word_t;

  class lpm_tracker;
    route_entry_t  routes[ENTRIES];
    bit            live[ENTRIES];
    route_result_t hops_due[$];
    int            faults;

    function void flag(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      faults++;
      if (faults <= 10) begin
        $display("%t %s: expected %h got %h", $realtime, what, want, got);
      end
    endfunction

    function void take_word(route_word_t w);
      route_result_t     hop;
      logic [ADDR_W-1:0] best;
      if (w.action == ACT_WRITE) begin
        if (w.slot < ENTRIES && w.route.port < PORTS) begin
          live[w.slot]   = w.live;
          routes[w.slot] = w.route;
        end
      end else begin
        hop  = '0;
        best = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i] && ((w.address ^ routes[i].destination) & routes[i].mask) == '0 &&
              (routes[i].mask & best) == best) begin
            best            = routes[i].mask;
            hop.found       = 1'b1;
            hop.hop_gateway = routes[i].gateway;
            hop.out_port    = routes[i].port;
          end
        end
        hops_due.push_back(hop);
      end
    endfunction

    function void check_hop(route_result_t got);
      route_result_t want;
      if (hops_due.size() == 0) begin
        flag("result word with no lookup pending, hop_gateway", '0, got.hop_gateway);
        return;
      end
      want = hops_due.pop_front();
      if (got.found !== want.found) begin
        flag("found", ADDR_W'(want.found), ADDR_W'(got.found));
      end
      if (got.hop_gateway !== want.hop_gateway) begin
        flag("hop_gateway", want.hop_gateway, got.hop_gateway);
      end
      if (got.out_port !== want.out_port) begin
        flag("out_port", ADDR_W'(want.out_port), ADDR_W'(got.out_port));
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [135:0]  s_tdata = '0;
  logic [0:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [39:0]   m_tdata;
  route_result_t out_word;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  lpm_tracker tracker = new();

  assign out_word = {m_tdata[0], m_tdata[32:1], m_tdata[34:33]};

  longest_prefix_route_lookup #(
    .ENTRIES(ENTRIES),
    .PORTS  (PORTS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        tracker.check_hop(out_word);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic int live_slot();
    int idx;
    for (int n = 0; n < 32; n++) begin
      idx = $urandom_range(ENTRIES - 1);
      if (tracker.live[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic route_word_t noise_word();
    route_word_t w;
    w.action            = 1'($urandom_range(1));
    w.slot              = SLOT_W'($urandom_range(ENTRIES - 1));
    w.live              = 1'($urandom_range(1));
    w.route.destination = $urandom;
    w.route.mask        = $urandom;
    w.route.gateway     = $urandom;
    w.route.port        = PORT_W'($urandom_range(PORTS - 1));
    w.address           = $urandom;
    return w;
  endfunction

  function automatic route_word_t mk_write(int slot, bit live, logic [ADDR_W-1:0] dest,
                                           logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] gw,
                                           int port);
    route_word_t w;
    w                   = noise_word();
    w.action            = ACT_WRITE;
    w.slot              = SLOT_W'(slot);
    w.live              = live;
    w.route.destination = dest;
    w.route.mask        = mask;
    w.route.gateway     = gw;
    w.route.port        = PORT_W'(port);
    return w;
  endfunction

  function automatic route_word_t mk_lookup(logic [ADDR_W-1:0] addr);
    route_word_t w;
    w         = noise_word();
    w.action  = ACT_LOOKUP;
    w.address = addr;
    return w;
  endfunction

  // Writes mostly carry prefix masks and often extend an existing route, so that
  // nested and equal prefixes build up in the table.
  function automatic route_word_t random_write();
    route_word_t w;
    int          pick;
    int          src;
    w        = noise_word();
    w.action = ACT_WRITE;
    w.live   = ($urandom_range(99) < 85);
    pick     = $urandom_range(99);
    if (pick < 65) begin
      w.route.mask = prefix_mask($urandom_range(ADDR_W));
    end else if (pick < 85) begin
      w.route.mask = prefix_mask(8 * $urandom_range(4));
    end
    src = live_slot();
    if (src >= 0 && $urandom_range(99) < 50) begin
      w.route.destination = tracker.routes[src].destination ^
                            ($urandom & ~prefix_mask($urandom_range(ADDR_W)));
    end
    return w;
  endfunction

  function automatic route_word_t random_lookup();
    route_word_t w;
    int          src;
    w   = mk_lookup($urandom);
    src = live_slot();
    if (src >= 0 && $urandom_range(99) < 75) begin
      w.address = tracker.routes[src].destination ^ ($urandom & ~tracker.routes[src].mask);
    end
    return w;
  endfunction

  task automatic send_word(input route_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, w.address, w.route.port, w.route.gateway, w.route.mask,
                 w.route.destination, w.live, w.slot};
    s_tuser  <= w.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_word(w);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.hops_due.size() != 0);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      send_word(($urandom_range(99) < 55) ? random_lookup() : random_write());
    end
    drain();
  endtask

  initial begin
    route_word_t plan[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(mk_lookup(32'h0000_0000));
    plan.push_back(mk_lookup(32'hFFFF_FFFF));
    plan.push_back(mk_write(0, 1, $urandom, 32'h0, 32'h0A00_0001, 1));
    plan.push_back(mk_lookup(32'h1234_5678));
    plan.push_back(mk_write(3, 1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2));
    plan.push_back(mk_write(7, 1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 3));
    plan.push_back(mk_lookup(32'hC0A8_0105));
    plan.push_back(mk_lookup(32'hC0A8_0205));
    plan.push_back(mk_write(9, 1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hDEAD_BEEF, 0));
    plan.push_back(mk_lookup(32'hC0A8_01AA));
    plan.push_back(mk_write(12, 1, 32'h0, 32'h0000_00FF, 32'h1111_1111, 1));
    plan.push_back(mk_lookup(32'hC0A8_0100));
    plan.push_back(mk_write(15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3));
    plan.push_back(mk_lookup(32'hFFFF_FFFF));
    plan.push_back(mk_write(9, 0, $urandom, $urandom, $urandom, 2));
    plan.push_back(mk_lookup(32'hC0A8_01AA));
    plan.push_back(mk_write(0, 0, $urandom, $urandom, $urandom, 1));
    plan.push_back(mk_lookup(32'h1234_5678));
    plan.push_back(mk_write(1, 1, 32'h0, 32'hFFFF_FFFF, 32'h0, 0));
    plan.push_back(mk_lookup(32'h0000_0000));
    plan.push_back(mk_write(5, 1, 32'h8000_0000, 32'h8000_0001, 32'h5555_AAAA, 2));
    plan.push_back(mk_lookup(32'h8765_4320));
    plan.push_back(mk_lookup(32'h8765_4321));
    foreach (plan[i]) send_word(plan[i]);
    drain();

    run_phase(0, 0, PHASE_WORDS);
    run_phase(84, 0, PHASE_WORDS);
    run_phase(0, 84, PHASE_WORDS);
    run_phase(29, 29, PHASE_WORDS);

    repeat (30) @(posedge clk);
    if (tracker.faults == 0 && tracker.hops_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> longest_prefix_route_lookup.f
hw/rtl/lprl_pkg.sv
hw/rtl/lprl_table.sv
hw/rtl/lprl_scan.sv
hw/rtl/longest_prefix_route_lookup.sv
bench/tb_longest_prefix_route_lookup.sv
